### sv/tksr_pkg.sv
// tksr_pkg: shared types and codes for the top-k score ranker.
// No dependencies; imported by tksr_ctrl, tksr_dpath and top_k_score_ranker.
`default_nettype none
package tksr_pkg;

	// Input item kinds (carried on s_tuser)
	typedef enum logic [1:0] {
		KIND_HIT   = 2'd0,
		KIND_EMIT  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// Configuration register indexes
	localparam logic CFG_PAGE_INDEX = 1'b0;
	localparam logic CFG_PAGE_SIZE  = 1'b1;

	localparam int unsigned MAX_PAGE   = 16;
	localparam int unsigned PAGES_SAT  = 31;
	localparam int unsigned OUT_BITS   = 80;
	localparam int unsigned IN_BITS    = 64;

	// Controller -> datapath commands
	typedef struct packed {
		logic hit;
		logic clear;
		logic start;
		logic step;
		logic setup;
		logic load;
	} dp_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic calc_done;
		logic last_beat;
		logic slot_free;
	} dp_sts_t;

endpackage
`default_nettype wire

### sv/tksr_ctrl.sv
// tksr_ctrl: sequencer for the ranker (accept, page count, page setup, beat emission).
// Depends on tksr_pkg.
`default_nettype none
module tksr_ctrl
	import tksr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_fire,
	input  wire logic [1:0] in_kind,
	input  wire dp_sts_t    sts,
	output logic            in_ready,
	output dp_cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CALC  = 4'b0010,
		ST_SETUP = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.hit   = (in_kind == KIND_HIT);
					cmd.clear = (in_kind == KIND_CLEAR);
					if (in_kind == KIND_EMIT) begin
						cmd.start = 1'b1;
						state_d   = ST_CALC;
					end
				end
			end
			ST_CALC: begin
				cmd.step = 1'b1;
				if (sts.calc_done) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.slot_free) begin
					cmd.load = 1'b1;
					if (sts.last_beat) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

### sv/tksr_dpath.sv
// tksr_dpath: sorted insertion chain, config registers, page counter and output register.
// Depends on tksr_pkg.
`default_nettype none
module tksr_dpath
	import tksr_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dp_cmd_t             cmd,
	output dp_sts_t                  sts,
	input  wire logic [31:0]         in_doc_id,
	input  wire logic [31:0]         in_score,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [4:0]          cfg_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [OUT_BITS-1:0]      out_data,
	output logic                     out_last
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int AW = $clog2(CAPACITY + MAX_PAGE + 1);

	logic [31:0] scores_q [CAPACITY];
	logic [31:0] ids_q    [CAPACITY];
	logic [CW-1:0] count_q;
	logic [3:0]    page_idx_q;
	logic [4:0]    page_size_q;

	logic [4:0]    size_q;
	logic [4:0]    pages_q;
	logic [AW-1:0] acc_q;
	logic          empty_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] end_q;
	logic [3:0]    pos_q;

	logic [31:0] doc_q, score_q;
	logic [3:0]  opos_q;
	logic [4:0]  opages_q;
	logic        oempty_q, olast_q, ovalid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_idx_q  <= '0;
			page_size_q <= 5'(MAX_PAGE);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAGE_INDEX: page_idx_q  <= cfg_data[3:0];
				CFG_PAGE_SIZE:  page_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// insertion chain: each slot keeps, takes the new hit, or takes its upper neighbor
	logic [CAPACITY-1:0] ge;
	logic full, take;
	always_comb begin
		for (int i = 0; i < CAPACITY; i++)
			ge[i] = (CW'(i) < count_q) && (scores_q[i] >= in_score);
	end
	assign full = (count_q == CW'(CAPACITY));
	assign take = !full || (in_score > scores_q[CAPACITY-1]);

	always_ff @(posedge clk) begin
		if (cmd.hit && take) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (!ge[i]) begin
					if (i == 0 || ge[(i > 0) ? i - 1 : 0]) begin
						scores_q[i] <= in_score;
						ids_q[i]    <= in_doc_id;
					end else begin
						scores_q[i] <= scores_q[(i > 0) ? i - 1 : 0];
						ids_q[i]    <= ids_q[(i > 0) ? i - 1 : 0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                       count_q <= '0;
		else if (cmd.clear)                count_q <= '0;
		else if (cmd.hit && take && !full) count_q <= count_q + 1'b1;
	end

	// page count by repeated addition of the page size
	logic [AW-1:0] from_w, end_w, cnt_w;
	assign cnt_w          = AW'(count_q);
	assign sts.calc_done  = (size_q == '0) || (acc_q >= cnt_w);
	assign from_w         = AW'(page_idx_q) * AW'(size_q);
	assign end_w          = ((from_w + AW'(size_q)) > cnt_w) ? cnt_w : (from_w + AW'(size_q));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			size_q  <= (page_size_q > 5'(MAX_PAGE)) ? 5'(MAX_PAGE) : page_size_q;
			acc_q   <= '0;
			pages_q <= '0;
		end else if (cmd.step && !sts.calc_done) begin
			acc_q <= acc_q + AW'(size_q);
			if (pages_q != 5'(PAGES_SAT)) pages_q <= pages_q + 1'b1;
		end
		if (cmd.setup) begin
			empty_q <= (size_q == '0) || ({1'b0, page_idx_q} >= pages_q);
			k_q     <= from_w;
			end_q   <= end_w;
			pos_q   <= '0;
		end else if (cmd.load) begin
			k_q   <= k_q + 1'b1;
			pos_q <= pos_q + 1'b1;
		end
	end

	assign sts.last_beat = empty_q || ((k_q + 1'b1) == end_q);
	assign sts.slot_free = !ovalid_q || out_ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        ovalid_q <= 1'b0;
		else if (cmd.load)  ovalid_q <= 1'b1;
		else if (out_ready) ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opages_q <= pages_q;
			oempty_q <= empty_q;
			olast_q  <= sts.last_beat;
			if (empty_q) begin
				doc_q   <= '0;
				score_q <= '0;
				opos_q  <= '0;
			end else begin
				doc_q   <= ids_q[k_q[IW-1:0]];
				score_q <= scores_q[k_q[IW-1:0]];
				opos_q  <= pos_q;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign out_last  = olast_q;
	assign out_data  = {6'd0, oempty_q, opages_q, opos_q, score_q, doc_q};

endmodule
`default_nettype wire

### sv/top_k_score_ranker.sv
// top_k_score_ranker: keeps the CAPACITY best (doc_id, score) hits, pages them out by rank.
// Depends on tksr_pkg, tksr_ctrl, tksr_dpath.
//
//  channel | dir | handshake        | payload
//  s_*     | in  | tvalid/tready    | tdata {score, doc_id}, tuser kind
//  m_*     | out | tvalid/tready    | tdata {empty_page,total_pages,position,score_out,doc_id_out}
//  cfg_*   | in  | cfg_we           | cfg_index, cfg_data
//
// The insertion chain compares all slots of a hit at once.
// Emit: the page count by repeated addition of the page size, then a setup state,
// then one result beat per cycle while m_tready is high.
// Reset empties the store at once; no clearing pass.
// s_tready is low from an emit's acceptance until its last beat is loaded.
`default_nettype none
module top_k_score_ranker
	import tksr_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [IN_BITS-1:0]  s_tdata,   // [31:0] doc_id, [63:32] score
	input  wire logic [1:0]          s_tuser,   // [1:0] kind
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OUT_BITS-1:0]      m_tdata,   // doc_id_out, score_out, position, total_pages, empty_page
	output logic                     m_tlast,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [4:0]          cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    in_fire;

	assign in_fire = s_tvalid && s_tready;

	tksr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_kind  (s_tuser),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	tksr_dpath #(.CAPACITY(CAPACITY)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_doc_id (s_tdata[31:0]),
		.in_score  (s_tdata[63:32]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
`default_nettype wire

### sv/tksr_checker.sv
// tksr_checker: port-level assertions for top_k_score_ranker, with its bind.
// Depends on tksr_pkg and top_k_score_ranker.
`default_nettype none
module tksr_checker
	import tksr_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [OUT_BITS-1:0] m_tdata,
	input wire logic                m_tlast
);

	// a beat waiting on the master side holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat dropped or changed while stalled");

	// an empty-page beat is always the only one of its emit
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[73] |-> m_tlast)
		else $error("empty page beat without last");

	// an empty-page beat carries zero id, score and position
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[73] |-> m_tdata[67:0] == '0)
		else $error("empty page beat with nonzero payload");

	// no new item enters while an emit still has beats to produce
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input accepted in the middle of an emit");

endmodule

bind top_k_score_ranker tksr_checker u_tksr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

### bench/tb_top_k_score_ranker.sv
// tb_top_k_score_ranker: self-checking bench for the top-k score ranker.
// Depends on tksr_pkg and top_k_score_ranker; a built-in ranking predictor checks every beat.
`default_nettype none
module tb_top_k_score_ranker;
	import tksr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;

	typedef struct {
		kind_t       kind;
		logic [31:0] doc_id;
		logic [31:0] score;
	} hit_item_t;

	typedef struct {
		logic [31:0] doc_id;
		logic [31:0] score;
		logic [3:0]  position;
		logic [4:0]  total_pages;
		logic        empty_page;
		logic        last;
	} ranked_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [IN_BITS-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid, m_tready, m_tlast;
	logic [OUT_BITS-1:0] m_tdata;
	logic cfg_we, cfg_index;
	logic [4:0] cfg_data;

	top_k_score_ranker dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state: ranked list, best score first
	logic [31:0] rank_score [DEPTH];
	logic [31:0] rank_doc [DEPTH];
	int unsigned rank_count;
	logic [3:0]  cur_page;
	logic [4:0]  cur_size;

	hit_item_t item_q[$];
	ranked_t   page_q[$];
	int errors, n_hits, n_emits, n_beats;
	bit quiet;
	int s_gap, m_gap;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("top_k_score_ranker test failed");
		$finish;
	end

	// insert behind every entry scoring >= the new one; full store drops the tail
	task automatic pred_insert(logic [31:0] id, logic [31:0] sc);
		int unsigned pos;
		pos = 0;
		if (rank_count >= DEPTH) begin
			if (!(sc > rank_score[DEPTH-1])) return;
			rank_count = DEPTH - 1;
		end
		while (pos < rank_count && rank_score[pos] >= sc) pos++;
		for (int unsigned i = rank_count; i > pos; i--) begin
			rank_score[i] = rank_score[i-1];
			rank_doc[i]   = rank_doc[i-1];
		end
		rank_score[pos] = sc;
		rank_doc[pos]   = id;
		rank_count++;
	endtask

	task automatic rank_page();
		int unsigned size, pages, from, upto;
		ranked_t r;
		size  = (cur_size > MAX_PAGE) ? MAX_PAGE : cur_size;
		pages = (size == 0) ? 0 : (rank_count + size - 1) / size;
		if (pages > PAGES_SAT) pages = PAGES_SAT;
		if (size == 0 || cur_page >= pages) begin
			r = '{0, 0, 0, pages[4:0], 1'b1, 1'b1};
			page_q.push_back(r);
			return;
		end
		from = cur_page * size;
		upto = (from + size > rank_count) ? rank_count : from + size;
		for (int unsigned i = 0; i < upto - from; i++) begin
			r = '{rank_doc[from+i], rank_score[from+i], i[3:0], pages[4:0], 1'b0,
				(from + i + 1 == upto)};
			page_q.push_back(r);
		end
	endtask

	// driver: next item from the queue, random gap bursts; predict on each accepted beat
	always @(posedge clk or negedge arst_n) begin
		hit_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				case (kind_t'(s_tuser))
					KIND_HIT: begin
						pred_insert(s_tdata[31:0], s_tdata[63:32]);
						n_hits++;
					end
					KIND_EMIT: begin
						rank_page();
						n_emits++;
					end
					KIND_CLEAR: rank_count = 0;
					default: ;
				endcase
			end
			if (!s_tvalid || s_tready) begin
				if (s_gap > 0) begin
					s_gap--;
					s_tvalid <= 1'b0;
				end else if (item_q.size() != 0) begin
					it = item_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= it.kind;
					s_tdata  <= {it.score, it.doc_id};
					if (!quiet && $urandom_range(0, 5) == 0) s_gap = $urandom_range(1, 8);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result beat against the oldest expected rank entry
	always @(posedge clk or negedge arst_n) begin
		ranked_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
			m_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_beats++;
				if (page_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result beat %h", m_tdata);
				end else begin
					e = page_q.pop_front();
					if (m_tdata[31:0] !== e.doc_id || m_tdata[63:32] !== e.score ||
					    m_tdata[67:64] !== e.position || m_tdata[72:68] !== e.total_pages ||
					    m_tdata[73] !== e.empty_page || m_tlast !== e.last ||
					    m_tdata[79:74] !== 6'd0) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: exp doc %h score %h pos %0d pages %0d %s",
								e.doc_id, e.score, e.position, e.total_pages,
								$sformatf("empty %b last %b", e.empty_page, e.last));
							$display("          got doc %h score %h pos %0d pages %0d %s",
								m_tdata[31:0], m_tdata[63:32], m_tdata[67:64],
								m_tdata[72:68],
								$sformatf("empty %b last %b", m_tdata[73], m_tlast));
						end
					end
				end
			end
			if (m_gap > 0) begin
				m_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0) m_gap = $urandom_range(1, 8);
			end
		end
	end

	function automatic void add(kind_t k, logic [31:0] id, logic [31:0] sc);
		hit_item_t it;
		it = '{k, id, sc};
		item_q.push_back(it);
	endfunction

	function automatic logic [31:0] pick_score();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 7) << 16;  // few distinct values: ties
			default: return $urandom;
		endcase
	endfunction

	task automatic settle();
		while (item_q.size() != 0 || s_tvalid || page_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [4:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PAGE_INDEX) cur_page = val[3:0];
		else cur_size = val;
	endtask

	task automatic random_run(int count);
		int unsigned roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 78) add(KIND_HIT, $urandom, pick_score());
			else if (roll < 93) add(KIND_EMIT, $urandom, $urandom);
			else if (roll < 97) add(KIND_CLEAR, $urandom, $urandom);
			else add(KIND_NONE, $urandom, $urandom);
		end
	endtask

	initial begin
		logic [4:0] sizes [6];
		logic [3:0] pages [6];
		sizes = '{5'd0, 5'd31, 5'd1, 5'd3, 5'd5, 5'd16};
		pages = '{4'd0, 4'd0, 4'd15, 4'd5, 4'd2, 4'd0};
		errors = 0; n_hits = 0; n_emits = 0; n_beats = 0;
		quiet = 0;
		rank_count = 0; cur_page = 0; cur_size = 16;
		arst_n = 0; s_tvalid = 0; s_tdata = '0; s_tuser = '0;
		m_tready = 0; cfg_we = 0; cfg_index = 0; cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty store, ignored kind, extremes, ties, full store and eviction
		add(KIND_EMIT, 0, 0);
		add(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add(KIND_HIT, 32'h0, 32'h0);
		add(KIND_HIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add(KIND_HIT, 32'd5, 32'h0);
		add(KIND_EMIT, 0, 0);
		for (int i = 0; i < 13; i++) add(KIND_HIT, 32'h100 + i, 32'h0001_0000);
		add(KIND_HIT, 32'hAAAA_5555, 32'h0);     // tie with the tail: dropped
		add(KIND_HIT, 32'h5555_AAAA, 32'h1);     // beats the tail: evicts newest zero
		add(KIND_EMIT, 0, 0);
		add(KIND_CLEAR, 0, 0);
		add(KIND_EMIT, 0, 0);
		random_run(40);
		settle();

		// register sweeps including size zero, oversized size and the last page index
		for (int p = 0; p < 6; p++) begin
			if (p == 5) quiet = 1;
			write_reg(CFG_PAGE_SIZE, sizes[p]);
			write_reg(CFG_PAGE_INDEX, pages[p]);
			random_run(55);
			settle();
		end

		$display("covered %0d hits and %0d page requests, %0d result beats checked",
			n_hits, n_emits, n_beats);
		if (errors == 0 && page_q.size() == 0) begin
			$display("top_k_score_ranker test passed");
		end else begin
			$display("errors: %0d, results still expected: %0d", errors, page_q.size());
			$display("top_k_score_ranker test failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
